@@ design/serial_frame_deframer_classifier_macros.svh @@
// Assertion macros used by the deframer module.
`ifndef SERIAL_FRAME_DEFRAMER_CLASSIFIER_MACROS_SVH
`define SERIAL_FRAME_DEFRAMER_CLASSIFIER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SFDC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SFDC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/sfdc_pkg.sv @@
package sfdc_pkg;

  localparam int unsigned MAX_FRAME_DEFAULT = 256;
  localparam logic [7:0]  MIN_LEN_RESET     = 8'd25;

  localparam logic [7:0] HEAD_FIRST  = 8'h7E;
  localparam logic [7:0] HEAD_SECOND = 8'h5A;
  localparam logic [7:0] TAIL_FIRST  = 8'h11;
  localparam logic [7:0] TAIL_SECOND = 8'h55;

  localparam logic [7:0] MARKER_BYTE = 8'hFF;
  localparam logic [7:0] IGNORE_BYTE = 8'h01;
  localparam logic [7:0] GROUP_ONE   = 8'h01;
  localparam logic [7:0] GROUP_TWO   = 8'h02;
  localparam logic [7:0] TYPE_MIN    = 8'h01;
  localparam logic [7:0] TYPE_MAX    = 8'h11;
  localparam logic [7:0] TYPE_RESET  = 8'h01;

  localparam int unsigned POS_MARKER_A = 9;
  localparam int unsigned POS_MARKER_B = 10;
  localparam int unsigned POS_IGNORE   = 13;
  localparam int unsigned POS_GROUP    = 23;
  localparam int unsigned POS_TYPE     = 24;
  localparam int unsigned POS_TAIL_MIN = 2;

  typedef logic [4:0] kind_t;

  localparam kind_t KIND_NONE          = 5'd0;
  localparam kind_t KIND_FACTORY_RESET = 5'd18;

  // Kind of a frame from its captured bytes, before the length check.
  function automatic kind_t classify(input logic       marker_ok,
                                     input logic       ignore,
                                     input logic [7:0] group_byte,
                                     input logic [7:0] type_byte);
    kind_t kind;
    kind = KIND_NONE;
    if (marker_ok && !ignore) begin
      if (group_byte == GROUP_ONE) begin
        if (type_byte >= TYPE_MIN && type_byte <= TYPE_MAX) begin
          kind = type_byte[4:0];
        end
      end else if (group_byte == GROUP_TWO && type_byte == TYPE_RESET) begin
        kind = KIND_FACTORY_RESET;
      end
    end
    return kind;
  endfunction

endpackage

@@ design/sfdc_byte_if.sv @@
interface sfdc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

@@ design/sfdc_cfg_if.sv @@
interface sfdc_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/sfdc_result_if.sv @@
interface sfdc_result_if;
  logic              valid;
  logic              ready;
  logic [7:0]        data;
  logic [7:0]        index;
  logic              frame_end;
  logic [8:0]        frame_length;
  sfdc_pkg::kind_t   kind;
  logic              overflow;

  modport source (output valid, output data, output index, output frame_end,
                  output frame_length, output kind, output overflow, input ready);
  modport sink (input valid, input data, input index, input frame_end,
                input frame_length, input kind, input overflow, output ready);
endinterface

@@ design/serial_frame_deframer_classifier.sv @@
// Channel  Direction  Payload
// cfg_i    in         data: minimum frame length, exclusive (8 bit)
// in_i     in         data_byte: received serial byte (8 bit)
// res_o    out        data, index, frame_end, frame_length, kind, overflow
//
// One byte is taken per cycle unless res_o stalls; its result is registered
// for the next cycle. A byte is taken whenever the output register is empty or
// is being emptied in the same cycle, so a stall on res_o holds back in_i.
// Bytes seen while hunting give no result, save the second header byte. Reset
// returns to hunting and sets the minimum length to 25; the configuration
// port is always ready.
`include "serial_frame_deframer_classifier_macros.svh"

module serial_frame_deframer_classifier #(
  parameter int unsigned MaxFrame = sfdc_pkg::MAX_FRAME_DEFAULT
) (
  input logic              clk_i,
  input logic              rst_ni,
  sfdc_cfg_if.sink         cfg_i,
  sfdc_byte_if.sink        in_i,
  sfdc_result_if.source    res_o
);

  localparam int unsigned PosW = $clog2(MaxFrame);
  localparam int unsigned LenW = PosW + 1;
  localparam int unsigned CmpW = (LenW > 8) ? LenW : 8;

  logic [7:0]      min_len_q;
  logic            in_frame_q, in_frame_d;
  logic            head_seen_q, head_seen_d;
  logic            tail_seen_q, tail_seen_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic            marker_ok_q, marker_ok_d;
  logic            ignore_q, ignore_d;
  logic [7:0]      group_q, group_d;
  logic [7:0]      type_q, type_d;

  logic            res_valid_q, res_valid_d;
  logic [7:0]      res_data_q, res_data_d;
  logic [7:0]      res_index_q, res_index_d;
  logic            res_end_q, res_end_d;
  logic [8:0]      res_len_q, res_len_d;
  sfdc_pkg::kind_t res_kind_q, res_kind_d;
  logic            res_ovf_q, res_ovf_d;
  logic            res_load;

  logic            accept;
  logic [7:0]      b;
  logic [PosW-1:0] pos_nx;
  logic [LenW-1:0] len;
  logic            closes;
  logic            at_limit;
  logic            long_enough;
  sfdc_pkg::kind_t kind_raw;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !res_valid_q || res_o.ready;
  assign accept      = in_i.valid && in_i.ready;
  assign b           = in_i.data_byte;

  assign pos_nx      = pos_q + PosW'(1);
  assign len         = {1'b0, pos_nx} + LenW'(1);
  assign closes      = tail_seen_q && (b == sfdc_pkg::TAIL_SECOND);
  assign at_limit    = (pos_nx == PosW'(MaxFrame - 1));
  assign long_enough = CmpW'(len) > CmpW'(min_len_q);

  always_comb begin
    in_frame_d  = in_frame_q;
    head_seen_d = head_seen_q;
    tail_seen_d = tail_seen_q;
    pos_d       = pos_q;
    marker_ok_d = marker_ok_q;
    ignore_d    = ignore_q;
    group_d     = group_q;
    type_d      = type_q;
    res_load    = 1'b0;
    res_data_d  = b;
    res_index_d = 8'(pos_nx);
    res_end_d   = 1'b0;
    res_len_d   = '0;
    res_kind_d  = sfdc_pkg::KIND_NONE;
    res_ovf_d   = 1'b0;
    kind_raw    = sfdc_pkg::KIND_NONE;

    if (accept) begin
      if (!in_frame_q) begin
        if (head_seen_q && b == sfdc_pkg::HEAD_SECOND) begin
          in_frame_d  = 1'b1;
          head_seen_d = 1'b0;
          tail_seen_d = 1'b0;
          pos_d       = PosW'(1);
          marker_ok_d = 1'b0;
          ignore_d    = 1'b0;
          group_d     = '0;
          type_d      = '0;
          res_load    = 1'b1;
          res_index_d = 8'd1;
        end else begin
          head_seen_d = (b == sfdc_pkg::HEAD_FIRST);
        end
      end else begin
        if (pos_nx == PosW'(sfdc_pkg::POS_MARKER_A)) begin
          marker_ok_d = (b == sfdc_pkg::MARKER_BYTE);
        end else if (pos_nx == PosW'(sfdc_pkg::POS_MARKER_B)) begin
          marker_ok_d = marker_ok_q && (b == sfdc_pkg::MARKER_BYTE);
        end else if (pos_nx == PosW'(sfdc_pkg::POS_IGNORE)) begin
          ignore_d = (b == sfdc_pkg::IGNORE_BYTE);
        end else if (pos_nx == PosW'(sfdc_pkg::POS_GROUP)) begin
          group_d = b;
        end else if (pos_nx == PosW'(sfdc_pkg::POS_TYPE)) begin
          type_d = b;
        end
        kind_raw = sfdc_pkg::classify(marker_ok_d, ignore_d, group_d, type_d);
        res_load = 1'b1;

        if (closes || at_limit) begin
          in_frame_d  = 1'b0;
          head_seen_d = 1'b0;
          tail_seen_d = 1'b0;
          pos_d       = '0;
          marker_ok_d = 1'b0;
          ignore_d    = 1'b0;
          group_d     = '0;
          type_d      = '0;
          res_end_d   = 1'b1;
          if (closes) begin
            res_len_d  = 9'(len);
            res_kind_d = long_enough ? kind_raw : sfdc_pkg::KIND_NONE;
          end else begin
            res_len_d = 9'(MaxFrame);
            res_ovf_d = 1'b1;
          end
        end else begin
          tail_seen_d = (pos_nx >= PosW'(sfdc_pkg::POS_TAIL_MIN)) &&
                        (b == sfdc_pkg::TAIL_FIRST);
          pos_d       = pos_nx;
        end
      end
    end

    res_valid_d = res_valid_q && !res_o.ready;
    if (res_load) begin
      res_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q   <= sfdc_pkg::MIN_LEN_RESET;
      in_frame_q  <= 1'b0;
      head_seen_q <= 1'b0;
      tail_seen_q <= 1'b0;
      pos_q       <= '0;
      marker_ok_q <= 1'b0;
      ignore_q    <= 1'b0;
      group_q     <= '0;
      type_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        min_len_q <= cfg_i.data;
      end
      in_frame_q  <= in_frame_d;
      head_seen_q <= head_seen_d;
      tail_seen_q <= tail_seen_d;
      pos_q       <= pos_d;
      marker_ok_q <= marker_ok_d;
      ignore_q    <= ignore_d;
      group_q     <= group_d;
      type_q      <= type_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_data_q  <= res_data_d;
      res_index_q <= res_index_d;
      res_end_q   <= res_end_d;
      res_len_q   <= res_len_d;
      res_kind_q  <= res_kind_d;
      res_ovf_q   <= res_ovf_d;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.data         = res_data_q;
  assign res_o.index        = res_index_q;
  assign res_o.frame_end    = res_end_q;
  assign res_o.frame_length = res_len_q;
  assign res_o.kind         = res_kind_q;
  assign res_o.overflow     = res_ovf_q;

  `SFDC_ASSERT_NOW(a_mid_frame_clean, clk_i, rst_ni,
    res_valid_q && !res_end_q,
    !res_ovf_q && res_kind_q == sfdc_pkg::KIND_NONE && res_len_q == '0,
    "Result before the end of a frame carries end-of-frame fields")
  `SFDC_ASSERT_NOW(a_overflow_shape, clk_i, rst_ni,
    res_valid_q && res_ovf_q,
    res_end_q && res_kind_q == sfdc_pkg::KIND_NONE,
    "Abandoned frame is not marked as an end without a kind")
  `SFDC_ASSERT_NOW(a_hunt_position, clk_i, rst_ni,
    !in_frame_q,
    pos_q == '0 && !tail_seen_q,
    "Frame position is not cleared while hunting")
  `SFDC_ASSERT_NEXT(a_stall_holds, clk_i, rst_ni,
    res_valid_q && !res_o.ready,
    res_valid_q && $stable(res_data_q) && $stable(res_index_q) && !$past(accept),
    "Stalled result was replaced or a byte was taken during a stall")

endmodule

@@ tb/serial_frame_deframer_classifier_test.sv @@
`timescale 1ns / 1ps

module serial_frame_deframer_classifier_test;

  localparam int unsigned DRAIN_LIMIT   = 5000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned PHASE_RESULTS = 10;

  typedef struct {
    logic [7:0]      data;
    logic [7:0]      index;
    logic            frame_end;
    logic [8:0]      frame_length;
    sfdc_pkg::kind_t kind;
    logic            overflow;
  } frame_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  sfdc_byte_if   byte_ch ();
  sfdc_cfg_if    cfg_ch ();
  sfdc_result_if res_ch ();

  serial_frame_deframer_classifier i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch),
    .in_i   (byte_ch),
    .res_o  (res_ch)
  );

  always #5 clk_i = ~clk_i;

  // Deframer state as the block should hold it.
  logic [7:0]  min_len;
  bit          in_frame;
  bit          saw_head_first;
  bit          saw_tail_first;
  int unsigned frame_pos;
  bit          markers_ok;
  bit          ignore_seen;
  logic [7:0]  group_val;
  logic [7:0]  type_val;

  frame_result_t frame_results[$];
  int unsigned   predicted_results = 0;
  int            mismatches = 0;
  bit            sender_idles = 1'b1;
  bit            result_stalls = 1'b1;

  function automatic void clear_frame();
    in_frame       = 1'b0;
    saw_head_first = 1'b0;
    saw_tail_first = 1'b0;
    frame_pos      = 0;
    markers_ok     = 1'b0;
    ignore_seen    = 1'b0;
    group_val      = 8'h00;
    type_val       = 8'h00;
  endfunction

  function automatic sfdc_pkg::kind_t expected_kind(input int unsigned length);
    if (length <= min_len) return sfdc_pkg::KIND_NONE;
    if (!markers_ok || ignore_seen) return sfdc_pkg::KIND_NONE;
    if (group_val == sfdc_pkg::GROUP_ONE) begin
      if (type_val >= sfdc_pkg::TYPE_MIN && type_val <= sfdc_pkg::TYPE_MAX) begin
        return sfdc_pkg::kind_t'(type_val[4:0]);
      end
      return sfdc_pkg::KIND_NONE;
    end
    if (group_val == sfdc_pkg::GROUP_TWO && type_val == sfdc_pkg::TYPE_RESET) begin
      return sfdc_pkg::KIND_FACTORY_RESET;
    end
    return sfdc_pkg::KIND_NONE;
  endfunction

  task automatic deframe_byte(input logic [7:0] b);
    frame_result_t res;
    int unsigned   pos;
    res = '{data: b, index: 8'd0, frame_end: 1'b0, frame_length: 9'd0,
            kind: sfdc_pkg::KIND_NONE, overflow: 1'b0};
    if (!in_frame) begin
      if (saw_head_first && b == sfdc_pkg::HEAD_SECOND) begin
        clear_frame();
        in_frame  = 1'b1;
        frame_pos = 1;
        res.index = 8'd1;
        frame_results.push_back(res);
        predicted_results++;
      end else begin
        saw_head_first = (b == sfdc_pkg::HEAD_FIRST);
      end
      return;
    end
    pos = frame_pos + 1;
    case (pos)
      sfdc_pkg::POS_MARKER_A: markers_ok = (b == sfdc_pkg::MARKER_BYTE);
      sfdc_pkg::POS_MARKER_B: markers_ok = markers_ok && (b == sfdc_pkg::MARKER_BYTE);
      sfdc_pkg::POS_IGNORE:   ignore_seen = (b == sfdc_pkg::IGNORE_BYTE);
      sfdc_pkg::POS_GROUP:    group_val = b;
      sfdc_pkg::POS_TYPE:     type_val = b;
      default: ;
    endcase
    res.index = pos[7:0];
    if (saw_tail_first && b == sfdc_pkg::TAIL_SECOND) begin
      res.frame_end    = 1'b1;
      res.frame_length = 9'(pos + 1);
      res.kind         = expected_kind(pos + 1);
      clear_frame();
    end else if (pos + 1 >= sfdc_pkg::MAX_FRAME_DEFAULT) begin
      // The abandoning byte closes the frame and cannot start a header.
      res.frame_end    = 1'b1;
      res.frame_length = 9'(sfdc_pkg::MAX_FRAME_DEFAULT);
      res.overflow     = 1'b1;
      clear_frame();
    end else begin
      saw_tail_first = (pos >= sfdc_pkg::POS_TAIL_MIN) && (b == sfdc_pkg::TAIL_FIRST);
      frame_pos      = pos;
    end
    frame_results.push_back(res);
    predicted_results++;
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 30);
  endfunction

  function automatic logic [7:0] rand_byte();
    if ($urandom_range(0, 99) >= 35) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 7))
      0: return sfdc_pkg::HEAD_FIRST;
      1: return sfdc_pkg::HEAD_SECOND;
      2: return sfdc_pkg::TAIL_FIRST;
      3: return sfdc_pkg::TAIL_SECOND;
      4: return sfdc_pkg::MARKER_BYTE;
      5: return sfdc_pkg::IGNORE_BYTE;
      6: return sfdc_pkg::GROUP_TWO;
      default: return 8'h00;
    endcase
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [8:0] got, input logic [8:0] want);
    if (got !== want) begin
      report_error($sformatf("%s is %h, expected %h", name, got, want));
    end
  endtask

  // Each transaction on the input channel runs the prediction at the accepting edge.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = sender_idles ? pick_gap() : 0;
    if (gap != 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= b;
    do @(posedge clk_i); while (!byte_ch.ready);
    deframe_byte(b);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    int unsigned waited;
    byte_ch.valid <= 1'b0;
    waited = 0;
    while (frame_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_min_length(input logic [7:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    min_len = value;
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_frame(input int unsigned len, input logic [7:0] mark_a,
                            input logic [7:0] mark_b, input logic [7:0] ign,
                            input logic [7:0] grp, input logic [7:0] typ);
    logic [7:0]  b;
    int unsigned p;
    send_byte(sfdc_pkg::HEAD_FIRST);
    send_byte(sfdc_pkg::HEAD_SECOND);
    for (p = 2; p < len; p++) begin
      if (p == len - 2) begin
        b = sfdc_pkg::TAIL_FIRST;
      end else if (p == len - 1) begin
        b = sfdc_pkg::TAIL_SECOND;
      end else begin
        case (p)
          sfdc_pkg::POS_MARKER_A: b = mark_a;
          sfdc_pkg::POS_MARKER_B: b = mark_b;
          sfdc_pkg::POS_IGNORE:   b = ign;
          sfdc_pkg::POS_GROUP:    b = grp;
          sfdc_pkg::POS_TYPE:     b = typ;
          default: begin
            b = rand_byte();
            if (b == sfdc_pkg::TAIL_FIRST) b = ~b;
          end
        endcase
      end
      send_byte(b);
    end
  endtask

  task automatic send_open_frame(input int unsigned count, input logic [7:0] last);
    logic [7:0]  b;
    int unsigned p;
    send_byte(sfdc_pkg::HEAD_FIRST);
    send_byte(sfdc_pkg::HEAD_SECOND);
    for (p = 2; p < count - 1; p++) begin
      b = rand_byte();
      if (b == sfdc_pkg::TAIL_FIRST) b = ~b;
      send_byte(b);
    end
    send_byte(last);
  endtask

  task automatic send_random_frame();
    int unsigned r;
    int unsigned len;
    logic [7:0]  grp;
    logic [7:0]  typ;
    r = $urandom_range(0, 99);
    if (r < 15) len = $urandom_range(4, 12);
    else if (r < 35) len = $urandom_range(13, 26);
    else if (r < 85) len = $urandom_range(27, 45);
    else len = $urandom_range(46, 120);
    r = $urandom_range(0, 99);
    if (r < 45) begin
      grp = sfdc_pkg::GROUP_ONE;
      typ = ($urandom_range(0, 9) != 0) ? 8'($urandom_range(0, 19)) : rand_byte();
    end else if (r < 80) begin
      grp = sfdc_pkg::GROUP_TWO;
      typ = ($urandom_range(0, 9) < 7) ? sfdc_pkg::TYPE_RESET : 8'($urandom_range(0, 3));
    end else begin
      grp = rand_byte();
      typ = rand_byte();
    end
    send_frame(len,
               ($urandom_range(0, 4) != 0) ? sfdc_pkg::MARKER_BYTE : rand_byte(),
               ($urandom_range(0, 4) != 0) ? sfdc_pkg::MARKER_BYTE : rand_byte(),
               ($urandom_range(0, 4) == 0) ? sfdc_pkg::IGNORE_BYTE : rand_byte(),
               grp, typ);
  endtask

  task automatic test_header_hunt();
    logic [7:0] stream[$];
    stream = '{sfdc_pkg::HEAD_SECOND, sfdc_pkg::HEAD_FIRST, 8'h00, sfdc_pkg::HEAD_SECOND,
               sfdc_pkg::HEAD_FIRST, sfdc_pkg::HEAD_FIRST, sfdc_pkg::HEAD_SECOND,
               sfdc_pkg::HEAD_FIRST, sfdc_pkg::HEAD_SECOND,
               sfdc_pkg::TAIL_FIRST, sfdc_pkg::TAIL_SECOND,
               sfdc_pkg::HEAD_FIRST, sfdc_pkg::HEAD_SECOND,
               sfdc_pkg::TAIL_FIRST, sfdc_pkg::TAIL_SECOND,
               sfdc_pkg::HEAD_FIRST, sfdc_pkg::HEAD_SECOND, sfdc_pkg::TAIL_FIRST,
               sfdc_pkg::TAIL_FIRST, sfdc_pkg::TAIL_SECOND,
               sfdc_pkg::HEAD_FIRST, sfdc_pkg::HEAD_SECOND, sfdc_pkg::TAIL_SECOND,
               sfdc_pkg::TAIL_FIRST, 8'h00,
               sfdc_pkg::TAIL_FIRST, sfdc_pkg::TAIL_SECOND};
    foreach (stream[i]) send_byte(stream[i]);
    drain_results();
  endtask

  task automatic test_kinds();
    send_frame(27, sfdc_pkg::MARKER_BYTE, sfdc_pkg::MARKER_BYTE, 8'h00,
               sfdc_pkg::GROUP_ONE, sfdc_pkg::TYPE_MIN);
    send_frame(27, sfdc_pkg::MARKER_BYTE, sfdc_pkg::MARKER_BYTE, sfdc_pkg::GROUP_TWO,
               sfdc_pkg::GROUP_ONE, sfdc_pkg::TYPE_MAX);
    send_frame(27, sfdc_pkg::MARKER_BYTE, sfdc_pkg::MARKER_BYTE, 8'h00,
               sfdc_pkg::GROUP_ONE, 8'h12);
    send_frame(27, sfdc_pkg::MARKER_BYTE, sfdc_pkg::MARKER_BYTE, 8'h00,
               sfdc_pkg::GROUP_ONE, 8'h00);
    send_frame(27, sfdc_pkg::MARKER_BYTE, sfdc_pkg::MARKER_BYTE, 8'hFE,
               sfdc_pkg::GROUP_TWO, sfdc_pkg::TYPE_RESET);
    send_frame(27, sfdc_pkg::MARKER_BYTE, sfdc_pkg::MARKER_BYTE, 8'h00,
               sfdc_pkg::GROUP_TWO, 8'h02);
    send_frame(27, 8'hFE, sfdc_pkg::MARKER_BYTE, 8'h00, sfdc_pkg::GROUP_ONE, 8'h05);
    send_frame(27, sfdc_pkg::MARKER_BYTE, 8'h7F, 8'h00, sfdc_pkg::GROUP_ONE, 8'h05);
    send_frame(27, sfdc_pkg::MARKER_BYTE, sfdc_pkg::MARKER_BYTE, sfdc_pkg::IGNORE_BYTE,
               sfdc_pkg::GROUP_ONE, 8'h05);
    drain_results();
  endtask

  task automatic test_min_length();
    write_min_length(8'd0);
    send_frame(4, sfdc_pkg::MARKER_BYTE, sfdc_pkg::MARKER_BYTE, 8'h00,
               sfdc_pkg::GROUP_ONE, 8'h05);
    send_frame(12, sfdc_pkg::MARKER_BYTE, sfdc_pkg::MARKER_BYTE, 8'h00,
               sfdc_pkg::GROUP_ONE, 8'h05);
    send_frame(27, sfdc_pkg::MARKER_BYTE, sfdc_pkg::MARKER_BYTE, 8'h00,
               sfdc_pkg::GROUP_TWO, sfdc_pkg::TYPE_RESET);
    drain_results();
    write_min_length(8'd255);
    send_frame(27, sfdc_pkg::MARKER_BYTE, sfdc_pkg::MARKER_BYTE, 8'h00,
               sfdc_pkg::GROUP_ONE, 8'h03);
    drain_results();
    write_min_length(8'd26);
    send_frame(27, sfdc_pkg::MARKER_BYTE, sfdc_pkg::MARKER_BYTE, 8'h00,
               sfdc_pkg::GROUP_ONE, 8'h04);
    send_frame(26, sfdc_pkg::MARKER_BYTE, sfdc_pkg::MARKER_BYTE, 8'h00,
               sfdc_pkg::GROUP_ONE, 8'h04);
    drain_results();
  endtask

  task automatic test_overflow();
    send_open_frame(sfdc_pkg::MAX_FRAME_DEFAULT, sfdc_pkg::HEAD_FIRST);
    send_byte(sfdc_pkg::HEAD_SECOND);
    send_byte(sfdc_pkg::TAIL_FIRST);
    send_byte(sfdc_pkg::TAIL_SECOND);
    send_frame(4, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    drain_results();
  endtask

  task automatic test_random_traffic();
    int unsigned phase;
    int unsigned start;
    int unsigned r;
    int unsigned n;
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_min_length(8'd0);
        1: write_min_length(8'd255);
        3: write_min_length(sfdc_pkg::MIN_LEN_RESET);
        5: write_min_length(8'd1);
        default: write_min_length(8'($urandom_range(0, 255)));
      endcase
      sender_idles  = (phase != 2) && (phase != 4);
      result_stalls = (phase != 2);
      start = predicted_results;
      while (predicted_results - start < PHASE_RESULTS) begin
        r = $urandom_range(0, 99);
        if (r < 72) begin
          send_random_frame();
        end else if (r < 84) begin
          n = $urandom_range(1, 6);
          repeat (n) send_byte(rand_byte());
        end else if (r < 92) begin
          send_byte(sfdc_pkg::HEAD_FIRST);
          send_byte(rand_byte());
        end else if (r < 97) begin
          send_open_frame($urandom_range(5, 40), rand_byte());
        end else begin
          drain_results();
        end
      end
      drain_results();
    end
    sender_idles  = 1'b1;
    result_stalls = 1'b1;
  endtask

  initial begin : drive_result_ready
    int unsigned stall_left;
    stall_left   = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left != 0) begin
        res_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        res_ch.ready <= 1'b1;
        if (result_stalls) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    frame_result_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (frame_results.size() == 0) begin
        report_error($sformatf("unexpected result: data %h index %0d",
                               res_ch.data, res_ch.index));
      end else begin
        want = frame_results.pop_front();
        check_field("data", 9'(res_ch.data), 9'(want.data));
        check_field("index", 9'(res_ch.index), 9'(want.index));
        check_field("frame_end", 9'(res_ch.frame_end), 9'(want.frame_end));
        check_field("frame_length", res_ch.frame_length, want.frame_length);
        check_field("kind", 9'(res_ch.kind), 9'(want.kind));
        check_field("overflow", 9'(res_ch.overflow), 9'(want.overflow));
      end
    end
  end

  initial begin
    byte_ch.valid     = 1'b0;
    byte_ch.data_byte = 8'h00;
    cfg_ch.valid      = 1'b0;
    cfg_ch.data       = 8'h00;
    rst_ni            = 1'b0;
    min_len           = sfdc_pkg::MIN_LEN_RESET;
    clear_frame();
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_header_hunt();
    test_kinds();
    test_min_length();
    test_overflow();
    test_random_traffic();
    drain_results();
    if (frame_results.size() != 0) begin
      report_error($sformatf("%0d results never arrived", frame_results.size()));
    end
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/sfdc_pkg.sv
design/sfdc_byte_if.sv
design/sfdc_cfg_if.sv
design/sfdc_result_if.sv
design/serial_frame_deframer_classifier.sv
tb/serial_frame_deframer_classifier_test.sv
